@@ rtl/core/stci_pkg.sv @@
// Shared types and constants for the speed to torque curve interpolator.
// Used by the channel interfaces, the divider, the register file and the top level.
package stci_pkg;

    localparam int SPD_W     = 10;
    localparam int TRQ_W     = 7;
    localparam int CUR_W     = 16;
    localparam int LIM_W     = 17;
    localparam int SEG_W     = 4;
    localparam int MAX_PTS   = 9;
    localparam int PTS_A     = 6;
    localparam int PTS_B     = 3;
    localparam int PT_W      = 4;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 2;

    localparam int SPA_W = PTS_A * SPD_W;
    localparam int SPB_W = PTS_B * SPD_W;
    localparam int TRQ_ALL_W = MAX_PTS * TRQ_W;

    // Divider sizing: the slope product is 7 x 10 bits, divided by a 10-bit speed step.
    localparam int PROD_W    = TRQ_W + SPD_W;
    localparam int DIVR_W    = SPD_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int DIV_CNT_W = 5;

    localparam int PCT_SCALE = 100;

    // The scaled current is 16 x 7 bits. Multiplying it by the reciprocal of the percent
    // scale, rounded up, and dropping RCP_SHIFT bits divides exactly for every such product.
    localparam int SCL_W     = CUR_W + TRQ_W;
    localparam int RCP_W     = 24;
    localparam int RCP_SHIFT = 30;
    localparam logic [RCP_W-1:0] RCP_MUL =
        RCP_W'(((64'd1 << RCP_SHIFT) + 64'(PCT_SCALE) - 64'd1) / 64'(PCT_SCALE));

    localparam logic [SEG_W-1:0] SEG_BELOW = 4'd0;
    localparam logic [SEG_W-1:0] SEG_ABOVE = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CUR = 2'd3;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/core/stci_if.sv @@
// Valid/ready channel interfaces for the speed input and the current limit output.
// Depends on stci_pkg for the field widths.
interface stci_in_if;
    import stci_pkg::*;

    logic             valid;
    logic             ready;
    logic [SPD_W-1:0] wheel_speed;

    modport source (output valid, output wheel_speed, input ready);
    modport sink (input valid, input wheel_speed, output ready);
endinterface

interface stci_out_if;
    import stci_pkg::*;

    logic             valid;
    logic             ready;
    logic [LIM_W-1:0] current_limit;
    logic [SEG_W-1:0] segment;
    logic             held;

    modport source (output valid, output current_limit, output segment, output held,
                    input ready);
    modport sink (input valid, input current_limit, input segment, input held,
                  output ready);
endinterface

@@ rtl/core/stci_div.sv @@
// Bit-serial restoring divider for the segment slope.
// Depends on stci_pkg for the request and response types.
module stci_div (
    input  logic               clk,
    input  logic               rst_n,
    input  stci_pkg::div_req_t req,
    output stci_pkg::div_rsp_t rsp
);
    import stci_pkg::*;

    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [DIVR_W-1:0]    rem_reg, rem_next;
    logic [DIVR_W-1:0]    dvs_reg, dvs_next;
    logic [DIVR_W:0]      trial;
    logic [DIVR_W:0]      diff;
    logic                 fits;

    always_comb
    begin
        trial       = {rem_reg, quo_reg[PROD_W-1]};
        diff        = trial - {1'b0, dvs_reg};
        fits        = trial >= {1'b0, dvs_reg};
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            rem_next    = '0;
            dvs_next    = req.divisor;
            cnt_next    = DIV_CNT_W'(DIV_STEPS);
            quo_next    = req.dividend;
        end
        else if (active_reg)
        begin
            quo_next = {quo_reg[PROD_W-2:0], fits};
            rem_next = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/core/stci_cfg.sv @@
// Configuration registers of the curve and the breakpoint selector.
// Depends on stci_pkg for register codes and field widths.
module stci_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [stci_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stci_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [stci_pkg::PT_W-1:0]       pt,
    output logic [stci_pkg::SPD_W-1:0]      speed,
    output logic [stci_pkg::TRQ_W-1:0]      torque,
    output logic [stci_pkg::CUR_W-1:0]      max_current
);
    import stci_pkg::*;

    logic [SPA_W-1:0]     spa_reg;
    logic [SPB_W-1:0]     spb_reg;
    logic [TRQ_ALL_W-1:0] trq_reg;
    logic [CUR_W-1:0]     cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spa_reg <= '0;
            spb_reg <= '0;
            trq_reg <= '0;
            cur_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED_A: spa_reg <= cfg_wdata[SPA_W-1:0];
                REG_SPEED_B: spb_reg <= cfg_wdata[SPB_W-1:0];
                REG_TORQUE:  trq_reg <= cfg_wdata[TRQ_ALL_W-1:0];
                REG_MAX_CUR: cur_reg <= cfg_wdata[CUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        speed  = '0;
        torque = '0;
        for (int i = 0; i < PTS_A; i++)
        begin
            if (pt == PT_W'(i))
                speed = spa_reg[i*SPD_W +: SPD_W];
        end
        for (int i = 0; i < PTS_B; i++)
        begin
            if (pt == PT_W'(i + PTS_A))
                speed = spb_reg[i*SPD_W +: SPD_W];
        end
        for (int i = 0; i < MAX_PTS; i++)
        begin
            if (pt == PT_W'(i))
                torque = trq_reg[i*TRQ_W +: TRQ_W];
        end
    end

    assign max_current = cur_reg;

endmodule

@@ rtl/core/speed_torque_curve_interpolator.sv @@
// Maps a wheel speed to a motor current limit through a curve of NUM_POINTS breakpoints.
// The block takes one item at a time: after an item is accepted it scans one breakpoint per
// cycle, then, for an item inside a segment, runs a bit-serial divider once for the segment
// slope (17 steps) and scales the percent with a multiply by the reciprocal of 100. An item
// that matches no breakpoint rule repeats the previous limit instead. A result still waiting
// to be taken holds the block in its output state until that result is taken.
// A finished result waits in an output register, so the next item can be accepted before it
// is taken. Configuration is written through cfg_we, cfg_index and cfg_wdata; the user must
// do so only while no item is in flight, which the block itself does not enforce.
module speed_torque_curve_interpolator #(
    parameter int NUM_POINTS = 9
) (
    input  logic                            clk,
    input  logic                            rst_n,
    stci_in_if.sink                         speed_ch,
    stci_out_if.source                      limit_ch,
    input  logic                            cfg_we,
    input  logic [stci_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stci_pkg::CFG_W-1:0]      cfg_wdata
);
    import stci_pkg::*;

    localparam int K_W = (NUM_POINTS > 2) ? $clog2(NUM_POINTS) : 1;
    localparam logic [K_W-1:0] K_LAST = K_W'(NUM_POINTS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_INTERP = 3'd3;
    localparam logic [2:0] ST_SCALE  = 3'd4;
    localparam logic [2:0] ST_SCLDIV = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [SPD_W-1:0] v_reg, v_next;
    logic             hit_reg, hit_next;
    logic             interp_reg, interp_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [TRQ_W-1:0] pct_reg, pct_next;
    logic [TRQ_W-1:0] t0_reg, t0_next;
    logic             neg_reg, neg_next;
    logic [TRQ_W-1:0] mag_reg, mag_next;
    logic [SPD_W-1:0] dv_reg, dv_next;
    logic [SPD_W-1:0] ds_reg, ds_next;
    logic [SPD_W-1:0] prev_s_reg, prev_s_next;
    logic [TRQ_W-1:0] prev_t_reg, prev_t_next;
    logic [SCL_W-1:0] scl_reg, scl_next;
    logic [LIM_W-1:0] lim_reg, lim_next;
    logic [LIM_W-1:0] last_limit_reg, last_limit_next;
    logic [SEG_W-1:0] last_segment_reg, last_segment_next;
    logic             out_valid_reg, out_valid_next;
    logic [LIM_W-1:0] out_lim_reg, out_lim_next;
    logic [SEG_W-1:0] out_seg_reg, out_seg_next;
    logic             out_held_reg, out_held_next;

    logic [SPD_W-1:0]       spd;
    logic [TRQ_W-1:0]       trq;
    logic [CUR_W-1:0]       max_cur;
    logic [PROD_W-1:0]      seg_prod;
    logic [SCL_W-1:0]       scl_prod;
    logic [SCL_W+RCP_W-1:0] rcp_prod;
    logic [TRQ_W-1:0]       q_pct;
    logic                   below, in_seg, above, load_out;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    stci_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .pt          (PT_W'(k_reg)),
        .speed       (spd),
        .torque      (trq),
        .max_current (max_cur)
    );

    stci_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign seg_prod = mag_reg * dv_reg;
    assign scl_prod = max_cur * pct_reg;
    assign rcp_prod = scl_reg * RCP_MUL;
    assign q_pct    = div_rsp.quotient[TRQ_W-1:0];

    // Rules of the current breakpoint; the above-last rule wins when it also matches.
    assign below  = (k_reg == '0) && (v_reg <= spd);
    assign in_seg = (k_reg != '0) && (prev_s_reg < v_reg) && (v_reg <= spd);
    assign above  = (k_reg == K_LAST) && (v_reg > spd);

    assign div_req.start    = (state_reg == ST_DECIDE) && hit_reg && interp_reg;
    assign div_req.dividend = seg_prod;
    assign div_req.divisor  = ds_reg;

    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || limit_ch.ready);

    always_comb
    begin
        state_next        = state_reg;
        k_next            = k_reg;
        v_next            = v_reg;
        hit_next          = hit_reg;
        interp_next       = interp_reg;
        seg_next          = seg_reg;
        pct_next          = pct_reg;
        t0_next           = t0_reg;
        neg_next          = neg_reg;
        mag_next          = mag_reg;
        dv_next           = dv_reg;
        ds_next           = ds_reg;
        prev_s_next       = prev_s_reg;
        prev_t_next       = prev_t_reg;
        scl_next          = scl_reg;
        lim_next          = lim_reg;
        last_limit_next   = last_limit_reg;
        last_segment_next = last_segment_reg;
        out_lim_next      = out_lim_reg;
        out_seg_next      = out_seg_reg;
        out_held_next     = out_held_reg;
        out_valid_next    = out_valid_reg && !limit_ch.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (speed_ch.valid)
                begin
                    v_next      = speed_ch.wheel_speed;
                    k_next      = '0;
                    hit_next    = 1'b0;
                    interp_next = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                prev_s_next = spd;
                prev_t_next = trq;
                if (above)
                begin
                    hit_next    = 1'b1;
                    interp_next = 1'b0;
                    seg_next    = SEG_ABOVE;
                    pct_next    = trq;
                end
                else if (in_seg)
                begin
                    hit_next    = 1'b1;
                    interp_next = 1'b1;
                    seg_next    = SEG_W'(k_reg);
                    t0_next     = prev_t_reg;
                    neg_next    = trq < prev_t_reg;
                    mag_next    = (trq < prev_t_reg) ? prev_t_reg - trq : trq - prev_t_reg;
                    dv_next     = v_reg - prev_s_reg;
                    ds_next     = spd - prev_s_reg;
                end
                else if (below)
                begin
                    hit_next    = 1'b1;
                    interp_next = 1'b0;
                    seg_next    = SEG_BELOW;
                    pct_next    = trq;
                end
                if (k_reg == K_LAST)
                    state_next = ST_DECIDE;
                else
                    k_next = k_reg + K_W'(1);
            end
            ST_DECIDE:
            begin
                if (!hit_reg)
                    state_next = ST_OUT;
                else if (interp_reg)
                    state_next = ST_INTERP;
                else
                    state_next = ST_SCALE;
            end
            ST_INTERP:
            begin
                // The quotient never exceeds the torque step, so the percent stays in range.
                if (div_rsp.done)
                begin
                    pct_next   = neg_reg ? t0_reg - q_pct : t0_reg + q_pct;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                scl_next   = scl_prod;
                state_next = ST_SCLDIV;
            end
            ST_SCLDIV:
            begin
                lim_next   = rcp_prod[RCP_SHIFT +: LIM_W];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_held_next  = !hit_reg;
                    if (hit_reg)
                    begin
                        out_lim_next      = lim_reg;
                        out_seg_next      = seg_reg;
                        last_limit_next   = lim_reg;
                        last_segment_next = seg_reg;
                    end
                    else
                    begin
                        out_lim_next = last_limit_reg;
                        out_seg_next = last_segment_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            k_reg            <= '0;
            hit_reg          <= 1'b0;
            interp_reg       <= 1'b0;
            last_limit_reg   <= '0;
            last_segment_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            hit_reg          <= hit_next;
            interp_reg       <= interp_next;
            last_limit_reg   <= last_limit_next;
            last_segment_reg <= last_segment_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        seg_reg      <= seg_next;
        pct_reg      <= pct_next;
        t0_reg       <= t0_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        dv_reg       <= dv_next;
        ds_reg       <= ds_next;
        prev_s_reg   <= prev_s_next;
        prev_t_reg   <= prev_t_next;
        scl_reg      <= scl_next;
        lim_reg      <= lim_next;
        out_lim_reg  <= out_lim_next;
        out_seg_reg  <= out_seg_next;
        out_held_reg <= out_held_next;
    end

    assign speed_ch.ready         = (state_reg == ST_IDLE);
    assign limit_ch.valid         = out_valid_reg;
    assign limit_ch.current_limit = out_lim_reg;
    assign limit_ch.segment       = out_seg_reg;
    assign limit_ch.held          = out_held_reg;

endmodule

@@ rtl/core/stci_chk.sv @@
// Port-level checker for the speed to torque curve interpolator, with its bind.
// Depends on stci_pkg for field widths.
module stci_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [stci_pkg::LIM_W-1:0]  current_limit,
    input logic [stci_pkg::SEG_W-1:0]  segment,
    input logic                        held
);
    import stci_pkg::*;

    logic [LIM_W-1:0] prev_lim_reg;
    logic [SEG_W-1:0] prev_seg_reg;

    // Tracks the last delivered item so that a repeated limit can be compared with it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_lim_reg <= '0;
            prev_seg_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            prev_lim_reg <= current_limit;
            prev_seg_reg <= segment;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(current_limit)
                                    && $stable(segment) && $stable(held))
        else $error("stalled result changed");

    a_held_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && held |-> current_limit == prev_lim_reg && segment == prev_seg_reg)
        else $error("held result differs from the previous one");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while an item is in work");

    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result presented while the block is still busy");

endmodule

bind speed_torque_curve_interpolator stci_chk u_stci_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (speed_ch.valid),
    .in_ready      (speed_ch.ready),
    .out_valid     (limit_ch.valid),
    .out_ready     (limit_ch.ready),
    .current_limit (limit_ch.current_limit),
    .segment       (limit_ch.segment),
    .held          (limit_ch.held)
);
